### sv/bpsc_pkg.sv
// ----------------------------------------------------------------------------
// bpsc_pkg
// Shared types and constants of the button PWM soft start controller.
// ----------------------------------------------------------------------------
package bpsc_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [4:0] DEBOUNCE_TICKS = 5'd20;

    typedef enum logic [2:0] {
        REG_START_DUTY    = 3'd0,
        REG_MAX_DUTY      = 3'd1,
        REG_RAMP_UP_STEP  = 3'd2,
        REG_COARSE_STEP   = 3'd3,
        REG_RAMP_INTERVAL = 3'd4,
        REG_FINE_INTERVAL = 3'd5,
        REG_DIR_HOLD      = 3'd6,
        REG_FINE_HOLD     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]  start_duty;
        logic [7:0]  max_duty;
        logic [7:0]  ramp_up_step;
        logic [7:0]  coarse_step;
        logic [9:0]  ramp_interval;
        logic [9:0]  fine_interval;
        logic [11:0] direction_hold_ticks;
        logic [11:0] fine_hold_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        start_duty:           8'd100,
        max_duty:             8'd255,
        ramp_up_step:         8'd5,
        coarse_step:          8'd25,
        ramp_interval:        10'd20,
        fine_interval:        10'd15,
        direction_hold_ticks: 12'd1500,
        fine_hold_ticks:      12'd1000
    };

    typedef struct packed {
        logic [4:0]  debounce_count;
        logic        debounce_ready;
        logic [9:0]  ramp_count;
        logic        ramp_due;
        logic [9:0]  fine_count;
        logic        fine_due;
        logic        start_active;
        logic [11:0] start_hold_count;
        logic        start_held;
        logic        start_last;
        logic        step_active;
        logic [11:0] step_hold_count;
        logic        step_held;
        logic        fine_on;
        logic        coarse_pending;
        logic        motor_on;
        logic        reverse_dir;
        logic [7:0]  duty_level;
    } state_t;

    typedef struct packed {
        logic [7:0] duty_out;
        logic       reverse_out;
        logic       motor_running;
        logic       fine_mode;
    } result_t;

endpackage

### sv/bpsc_apb_regs.sv
// ----------------------------------------------------------------------------
// bpsc_apb_regs
// APB configuration register file of the controller.
// ----------------------------------------------------------------------------
module bpsc_apb_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpsc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bpsc_pkg::DATA_W-1:0]  pwdata,
    output logic [bpsc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output bpsc_pkg::cfg_t               cfg
);

    bpsc_pkg::cfg_t     cfg_reg;
    bpsc_pkg::cfg_t     cfg_next;
    bpsc_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = bpsc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                bpsc_pkg::REG_START_DUTY:    cfg_next.start_duty = pwdata[7:0];
                bpsc_pkg::REG_MAX_DUTY:      cfg_next.max_duty = pwdata[7:0];
                bpsc_pkg::REG_RAMP_UP_STEP:  cfg_next.ramp_up_step = pwdata[7:0];
                bpsc_pkg::REG_COARSE_STEP:   cfg_next.coarse_step = pwdata[7:0];
                bpsc_pkg::REG_RAMP_INTERVAL: cfg_next.ramp_interval = pwdata[9:0];
                bpsc_pkg::REG_FINE_INTERVAL: cfg_next.fine_interval = pwdata[9:0];
                bpsc_pkg::REG_DIR_HOLD:      cfg_next.direction_hold_ticks = pwdata[11:0];
                bpsc_pkg::REG_FINE_HOLD:     cfg_next.fine_hold_ticks = pwdata[11:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            bpsc_pkg::REG_START_DUTY:    prdata = {24'd0, cfg_reg.start_duty};
            bpsc_pkg::REG_MAX_DUTY:      prdata = {24'd0, cfg_reg.max_duty};
            bpsc_pkg::REG_RAMP_UP_STEP:  prdata = {24'd0, cfg_reg.ramp_up_step};
            bpsc_pkg::REG_COARSE_STEP:   prdata = {24'd0, cfg_reg.coarse_step};
            bpsc_pkg::REG_RAMP_INTERVAL: prdata = {22'd0, cfg_reg.ramp_interval};
            bpsc_pkg::REG_FINE_INTERVAL: prdata = {22'd0, cfg_reg.fine_interval};
            bpsc_pkg::REG_DIR_HOLD:      prdata = {20'd0, cfg_reg.direction_hold_ticks};
            bpsc_pkg::REG_FINE_HOLD:     prdata = {20'd0, cfg_reg.fine_hold_ticks};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= bpsc_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/bpsc_core.sv
// ----------------------------------------------------------------------------
// bpsc_core
// Controller state and its single-pass update for one tick.
// ----------------------------------------------------------------------------
module bpsc_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  bpsc_pkg::cfg_t    cfg,
    input  logic              tick_en,
    input  logic              start_pressed,
    input  logic              step_pressed,
    output bpsc_pkg::result_t result
);

    bpsc_pkg::state_t state_reg;
    bpsc_pkg::state_t state_next;

    always_comb begin
        bpsc_pkg::state_t s;
        logic             due;
        logic [8:0]       sum;
        s   = state_reg;
        due = 1'b0;
        sum = '0;

        // Timers.
        if (s.debounce_count < bpsc_pkg::DEBOUNCE_TICKS) begin
            s.debounce_count = s.debounce_count + 5'd1;
        end else begin
            s.debounce_count = '0;
            s.debounce_ready = 1'b1;
        end
        s.ramp_count = s.ramp_count + 10'd1;
        if (s.ramp_count >= cfg.ramp_interval) begin
            s.ramp_count = '0;
            s.ramp_due   = 1'b1;
        end
        s.fine_count = s.fine_count + 10'd1;
        if (s.fine_count >= cfg.fine_interval) begin
            s.fine_count = '0;
            s.fine_due   = 1'b1;
        end
        if (s.start_active) begin
            s.start_hold_count = s.start_hold_count + 12'd1;
            if (s.start_hold_count == cfg.direction_hold_ticks) begin
                s.start_hold_count = '0;
                s.start_held       = 1'b1;
            end
        end
        if (s.step_active) begin
            s.step_hold_count = s.step_hold_count + 12'd1;
            if (s.step_hold_count == cfg.fine_hold_ticks) begin
                s.step_held = 1'b1;
            end
        end

        // Start button.
        priority if (start_pressed && !s.start_last && s.debounce_ready) begin
            s.start_active     = 1'b1;
            s.start_hold_count = '0;
            s.debounce_ready   = 1'b0;
            s.start_last       = 1'b1;
        end else if (!start_pressed && s.start_last && !s.start_held) begin
            if (s.debounce_ready) begin
                s.start_active   = 1'b0;
                s.motor_on       = !s.motor_on;
                s.start_last     = 1'b0;
                s.debounce_ready = 1'b0;
            end
        end else if (!start_pressed && s.start_last && s.start_held && s.motor_on) begin
            if (s.debounce_ready) begin
                s.start_active   = 1'b0;
                s.start_held     = 1'b0;
                s.start_last     = 1'b0;
                s.reverse_dir    = !s.reverse_dir;
                s.debounce_ready = 1'b0;
            end
        end else begin
            s.start_last = s.start_last;
        end

        // Soft ramp towards the start duty, or down to zero.
        due        = s.ramp_due;
        s.ramp_due = 1'b0;
        if (s.motor_on) begin
            if (s.duty_level < cfg.start_duty && due) begin
                sum = {1'b0, s.duty_level} + {1'b0, cfg.ramp_up_step};
                s.duty_level = (sum > {1'b0, cfg.start_duty}) ? cfg.start_duty : sum[7:0];
            end
        end else if (s.duty_level != 8'd0 && due) begin
            s.duty_level = s.duty_level - 8'd1;
        end

        // Step button.
        priority if (step_pressed && !s.step_active && s.motor_on) begin
            s.step_active     = 1'b1;
            s.step_hold_count = '0;
            s.debounce_ready  = 1'b0;
        end else if (step_pressed && s.step_held) begin
            s.fine_on = 1'b1;
        end else begin
            s.fine_on = s.fine_on;
        end
        priority if (!step_pressed && s.step_active) begin
            if (s.debounce_ready) begin
                s.coarse_pending = 1'b1;
                s.step_active    = 1'b0;
                s.debounce_ready = 1'b0;
            end
        end else if (!step_pressed && s.step_held) begin
            if (s.debounce_ready) begin
                s.fine_on         = 1'b0;
                s.step_hold_count = '0;
                s.step_active     = 1'b0;
                s.debounce_ready  = 1'b0;
            end
        end else begin
            s.step_active = s.step_active;
        end

        // Fine and coarse increments; a coarse step past the maximum falls back to the start duty.
        if (s.fine_on && s.duty_level != 8'd0 && s.fine_due) begin
            sum          = {1'b0, s.duty_level} + 9'd1;
            s.fine_due   = 1'b0;
            s.duty_level = (sum >= {1'b0, cfg.max_duty}) ? cfg.max_duty : sum[7:0];
        end
        if (s.coarse_pending && s.duty_level != 8'd0) begin
            sum              = {1'b0, s.duty_level} + {1'b0, cfg.coarse_step};
            s.duty_level     = (sum > {1'b0, cfg.max_duty}) ? cfg.start_duty : sum[7:0];
            s.coarse_pending = 1'b0;
        end

        state_next = s;
    end

    assign result.duty_out      = state_next.duty_level;
    assign result.reverse_out   = state_next.reverse_dir;
    assign result.motor_running = state_next.motor_on;
    assign result.fine_mode     = state_next.fine_on;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (tick_en) begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/button_pwm_soft_start_controller.sv
// ----------------------------------------------------------------------------
// button_pwm_soft_start_controller
// Debounced two-button PWM duty controller with soft start and stop ramps.
// ----------------------------------------------------------------------------
// Each request is one 1 ms tick carrying the two button levels and yields one
// result with the duty, direction, motor enable and fine mode after that tick.
// A request passes through an input register, one pass of update logic and an
// output register, so the block takes one request per clock cycle while the
// output is not stalled. A result waiting in the output register does not stop
// the next request from entering the input register. Configuration registers
// are written through the APB port by the user only while the block is idle;
// the block itself does not enforce this.
module button_pwm_soft_start_controller (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_start_button,
    input  logic                         s_step_button,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_duty_out,
    output logic                         m_reverse_out,
    output logic                         m_motor_running,
    output logic                         m_fine_mode,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpsc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bpsc_pkg::DATA_W-1:0]  pwdata,
    output logic [bpsc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    bpsc_pkg::cfg_t    cfg;
    bpsc_pkg::result_t result;
    bpsc_pkg::result_t out_reg;
    logic              in_valid_reg;
    logic              start_reg;
    logic              step_reg;
    logic              out_valid_reg;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    bpsc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpsc_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .tick_en       (advance),
        .start_pressed (start_reg),
        .step_pressed  (step_reg),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            start_reg <= s_start_button;
            step_reg  <= s_step_button;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_duty_out      = out_reg.duty_out;
    assign m_reverse_out   = out_reg.reverse_out;
    assign m_motor_running = out_reg.motor_running;
    assign m_fine_mode     = out_reg.fine_mode;

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid && !m_ready))
        else $error("Input stalled without a stalled result.");

    a_result_follows_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("Processed request produced no result.");

    a_update_needs_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !in_valid_reg) |-> 1'b0)
        else $error("Update enabled without a request.");

endmodule

### tb/sv/button_pwm_soft_start_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_pwm_soft_start_controller_tb
// Self-checking testbench for the button PWM soft start controller.
// ----------------------------------------------------------------------------
// Every accepted request is one tick with two button levels. A scoreboard
// keeps its own copy of the timers, button trackers, motor state and duty,
// predicts the result of each tick and compares the results in order. The
// stimulus runs press, hold and release sequences of both buttons, with some
// bouncing noise, under several register settings written over the APB port,
// while one or both handshakes stall in random bursts in most phases.
// ----------------------------------------------------------------------------

class duty_scoreboard;
    bpsc_pkg::cfg_t    cfg;
    bpsc_pkg::result_t expected_q[$];

    bit [4:0]    db_cnt;
    bit          db_rdy;
    bit [9:0]    ramp_cnt;
    bit          ramp_hit;
    bit [9:0]    fine_cnt;
    bit          fine_hit;
    bit          st_busy;
    bit [11:0]   st_cnt;
    bit          st_long;
    bit          st_prev;
    bit          sp_busy;
    bit [11:0]   sp_cnt;
    bit          sp_long;
    bit          fine_en;
    bit          coarse_req;
    bit          run;
    bit          rev;
    bit [7:0]    duty;

    int unsigned errors;
    int unsigned checked;
    int unsigned flips;
    int unsigned wraps;
    int unsigned fine_ticks;
    bit [7:0]    peak;

    function new();
        cfg = bpsc_pkg::CFG_RESET;
    endfunction

    function void set_reg(bpsc_pkg::reg_idx_t idx, logic [31:0] value);
        case (idx)
            bpsc_pkg::REG_START_DUTY:    cfg.start_duty = value[7:0];
            bpsc_pkg::REG_MAX_DUTY:      cfg.max_duty = value[7:0];
            bpsc_pkg::REG_RAMP_UP_STEP:  cfg.ramp_up_step = value[7:0];
            bpsc_pkg::REG_COARSE_STEP:   cfg.coarse_step = value[7:0];
            bpsc_pkg::REG_RAMP_INTERVAL: cfg.ramp_interval = value[9:0];
            bpsc_pkg::REG_FINE_INTERVAL: cfg.fine_interval = value[9:0];
            bpsc_pkg::REG_DIR_HOLD:      cfg.direction_hold_ticks = value[11:0];
            bpsc_pkg::REG_FINE_HOLD:     cfg.fine_hold_ticks = value[11:0];
            default: ;
        endcase
    endfunction

    function void note_tick(bit start_b, bit step_b);
        int unsigned       sum;
        bpsc_pkg::result_t r;

        if (db_cnt < bpsc_pkg::DEBOUNCE_TICKS) begin
            db_cnt = db_cnt + 5'd1;
        end else begin
            db_cnt = 5'd0;
            db_rdy = 1'b1;
        end
        ramp_cnt = ramp_cnt + 10'd1;
        if (ramp_cnt >= cfg.ramp_interval) begin
            ramp_cnt = 10'd0;
            ramp_hit = 1'b1;
        end
        fine_cnt = fine_cnt + 10'd1;
        if (fine_cnt >= cfg.fine_interval) begin
            fine_cnt = 10'd0;
            fine_hit = 1'b1;
        end
        if (st_busy) begin
            st_cnt = st_cnt + 12'd1;
            if (st_cnt == cfg.direction_hold_ticks) begin
                st_cnt = 12'd0;
                st_long = 1'b1;
            end
        end
        if (sp_busy) begin
            sp_cnt = sp_cnt + 12'd1;
            if (sp_cnt == cfg.fine_hold_ticks) begin
                sp_long = 1'b1;
            end
        end

        if (start_b && !st_prev && db_rdy) begin
            st_busy = 1'b1;
            st_cnt = 12'd0;
            db_rdy = 1'b0;
            st_prev = 1'b1;
        end else if (!start_b && st_prev && !st_long) begin
            if (db_rdy) begin
                st_busy = 1'b0;
                run = !run;
                st_prev = 1'b0;
                db_rdy = 1'b0;
            end
        end else if (!start_b && st_prev && st_long && run) begin
            if (db_rdy) begin
                st_busy = 1'b0;
                st_long = 1'b0;
                st_prev = 1'b0;
                rev = !rev;
                db_rdy = 1'b0;
                flips++;
            end
        end

        if (run) begin
            if (duty < cfg.start_duty && ramp_hit) begin
                sum = 32'(duty) + 32'(cfg.ramp_up_step);
                duty = (sum > 32'(cfg.start_duty)) ? cfg.start_duty : sum[7:0];
            end
        end else if (duty != 8'd0 && ramp_hit) begin
            duty = duty - 8'd1;
        end
        ramp_hit = 1'b0;

        if (step_b && !sp_busy && run) begin
            sp_busy = 1'b1;
            sp_cnt = 12'd0;
            db_rdy = 1'b0;
        end else if (step_b && sp_long) begin
            fine_en = 1'b1;
        end
        if (!step_b && sp_busy) begin
            if (db_rdy) begin
                coarse_req = 1'b1;
                sp_busy = 1'b0;
                db_rdy = 1'b0;
            end
        end else if (!step_b && sp_long) begin
            if (db_rdy) begin
                fine_en = 1'b0;
                sp_cnt = 12'd0;
                sp_busy = 1'b0;
                db_rdy = 1'b0;
            end
        end

        if (fine_en && duty != 8'd0 && fine_hit) begin
            sum = 32'(duty) + 32'd1;
            fine_hit = 1'b0;
            duty = (sum >= 32'(cfg.max_duty)) ? cfg.max_duty : sum[7:0];
        end
        if (coarse_req && duty != 8'd0) begin
            sum = 32'(duty) + 32'(cfg.coarse_step);
            if (sum > 32'(cfg.max_duty)) begin
                duty = cfg.start_duty;
                wraps++;
            end else begin
                duty = sum[7:0];
            end
            coarse_req = 1'b0;
        end

        if (fine_en) begin
            fine_ticks++;
        end
        if (duty > peak) begin
            peak = duty;
        end
        r.duty_out = duty;
        r.reverse_out = rev;
        r.motor_running = run;
        r.fine_mode = fine_en;
        expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_output(logic [7:0] d, logic r, logic m, logic f);
        bpsc_pkg::result_t want;

        if (expected_q.size() == 0) begin
            $display("%0t ns: result with no request outstanding, duty %0d", $time, d);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        compare_field("duty_out", want.duty_out, d);
        compare_field("reverse_out", 8'(want.reverse_out), 8'(r));
        compare_field("motor_running", 8'(want.motor_running), 8'(m));
        compare_field("fine_mode", 8'(want.fine_mode), 8'(f));
    endfunction
endclass

module button_pwm_soft_start_controller_tb;

    localparam int unsigned CYCLE_LIMIT = 500000;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_start_button;
    logic                        s_step_button;
    logic                        m_valid;
    logic                        m_ready;
    logic [7:0]                  m_duty_out;
    logic                        m_reverse_out;
    logic                        m_motor_running;
    logic                        m_fine_mode;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [bpsc_pkg::ADDR_W-1:0] paddr;
    logic [bpsc_pkg::DATA_W-1:0] pwdata;
    logic [bpsc_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    duty_scoreboard sb;
    int unsigned    cycle_count;
    int unsigned    src_rate;
    int unsigned    snk_rate;
    int unsigned    ticks_sent;
    int unsigned    tick_target;
    int unsigned    settings_used;

    button_pwm_soft_start_controller u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_button  (s_start_button),
        .s_step_button   (s_step_button),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_duty_out      (m_duty_out),
        .m_reverse_out   (m_reverse_out),
        .m_motor_running (m_motor_running),
        .m_fine_mode     (m_fine_mode),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.expected_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_tick(s_start_button, s_step_button);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_output(m_duty_out, m_reverse_out, m_motor_running, m_fine_mode);
        end
    end

    initial begin : result_sink
        int unsigned burst;
        burst = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (burst == 0 && snk_rate != 0 && $urandom_range(0, 99) < snk_rate) begin
                burst = $urandom_range(1, 15);
            end
            if (burst != 0) begin
                m_ready = 1'b0;
                burst--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic send_tick(input bit start_b, input bit step_b);
        int unsigned gap;
        gap = 0;
        if (src_rate != 0 && $urandom_range(0, 99) < src_rate) begin
            gap = $urandom_range(1, 15);
        end
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_start_button = start_b;
        s_step_button = step_b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        ticks_sent++;
    endtask

    task automatic hold_buttons(input bit start_b, input bit step_b, input int unsigned n);
        repeat (n) begin
            if (ticks_sent < tick_target) begin
                send_tick(start_b, step_b);
            end
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input bpsc_pkg::reg_idx_t idx, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic configure(input logic [7:0] sd, input logic [7:0] md,
                             input logic [7:0] rs, input logic [7:0] cs,
                             input logic [9:0] ri, input logic [9:0] fi,
                             input logic [11:0] dh, input logic [11:0] fh);
        write_reg(bpsc_pkg::REG_START_DUTY, 32'(sd));
        write_reg(bpsc_pkg::REG_MAX_DUTY, 32'(md));
        write_reg(bpsc_pkg::REG_RAMP_UP_STEP, 32'(rs));
        write_reg(bpsc_pkg::REG_COARSE_STEP, 32'(cs));
        write_reg(bpsc_pkg::REG_RAMP_INTERVAL, 32'(ri));
        write_reg(bpsc_pkg::REG_FINE_INTERVAL, 32'(fi));
        write_reg(bpsc_pkg::REG_DIR_HOLD, 32'(dh));
        write_reg(bpsc_pkg::REG_FINE_HOLD, 32'(fh));
        settings_used++;
    endtask

    task automatic random_ticks(input int unsigned count);
        int unsigned press_len;
        tick_target = ticks_sent + count;
        while (ticks_sent < tick_target) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    hold_buttons(1'b1, 1'b0, $urandom_range(1, 25));
                    hold_buttons(1'b0, 1'b0, $urandom_range(1, 30));
                end
                2: begin
                    press_len = (sb.cfg.direction_hold_ticks > 12'd150) ? 150
                                : 32'(sb.cfg.direction_hold_ticks);
                    hold_buttons(1'b1, 1'b0, press_len + $urandom_range(0, 25));
                    hold_buttons(1'b0, 1'b0, $urandom_range(15, 30));
                end
                3, 4: begin
                    hold_buttons(1'b0, 1'b1, $urandom_range(1, 25));
                    hold_buttons(1'b0, 1'b0, $urandom_range(1, 30));
                end
                5: begin
                    press_len = (sb.cfg.fine_hold_ticks > 12'd150) ? 150
                                : 32'(sb.cfg.fine_hold_ticks);
                    hold_buttons(1'b0, 1'b1, press_len + $urandom_range(0, 40));
                    hold_buttons(1'b0, 1'b0, $urandom_range(15, 40));
                end
                6: begin
                    hold_buttons(1'b1, 1'b1, $urandom_range(1, 30));
                    hold_buttons(1'b0, 1'b0, $urandom_range(1, 20));
                end
                7: begin
                    hold_buttons(1'b0, 1'b0, $urandom_range(1, 50));
                end
                8: begin
                    repeat ($urandom_range(4, 20)) begin
                        if (ticks_sent < tick_target) begin
                            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                        end
                    end
                end
                default: begin
                    hold_buttons(1'b1, 1'b0, $urandom_range(1, 20));
                    hold_buttons(1'b1, 1'b1, $urandom_range(1, 20));
                    hold_buttons(1'b0, 1'b1, $urandom_range(1, 20));
                    hold_buttons(1'b0, 1'b0, $urandom_range(1, 30));
                end
            endcase
        end
    endtask

    task automatic run_phase(input int unsigned count, input int unsigned sr,
                             input int unsigned kr);
        src_rate = sr;
        snk_rate = kr;
        random_ticks(count);
        drain();
    endtask

    initial begin : stimulus
        int unsigned k;

        sb = new();
        cycle_count = 0;
        ticks_sent = 0;
        tick_target = 32'hFFFF_FFFF;
        settings_used = 1;
        src_rate = 0;
        snk_rate = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_start_button = 1'b0;
        s_step_button = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        hold_buttons(1'b0, 1'b0, 21);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        drain();

        run_phase(150, 30, 30);
        configure(8'd200, 8'd250, 8'd50, 8'd30, 10'd1, 10'd1, 12'd5, 12'd8);
        run_phase(300, 20, 20);
        configure(8'd0, 8'd0, 8'd1, 8'd1, 10'd1, 10'd1, 12'd1, 12'd1);
        run_phase(150, 40, 0);
        configure(8'd255, 8'd255, 8'd255, 8'd255, 10'd1023, 10'd1023, 12'd4095, 12'd4095);
        run_phase(150, 0, 40);
        for (k = 0; k < 4; k++) begin
            configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                      10'($urandom_range(1, 40)), 10'($urandom_range(1, 40)),
                      12'($urandom_range(1, 60)), 12'($urandom_range(1, 60)));
            if (k == 3) begin
                run_phase(160, 0, 0);
            end else begin
                run_phase(160, 10 + 10 * k, 30 - 10 * k);
            end
        end

        repeat (10) @(negedge aclk);
        $display("Sent %0d ticks under %0d register settings, %0d results checked.",
                 ticks_sent, settings_used, sb.checked);
        $display("Saw %0d direction flips, %0d coarse overflows, %0d fine ticks, peak duty %0d.",
                 sb.flips, sb.wraps, sb.fine_ticks, sb.peak);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### button_pwm_soft_start_controller.f
sv/bpsc_pkg.sv
sv/bpsc_apb_regs.sv
sv/bpsc_core.sv
sv/button_pwm_soft_start_controller.sv
tb/sv/button_pwm_soft_start_controller_tb.sv
